### hw/rtl/nsc_pkg.sv
// Package for the sentence checker: character codes, limits, the running
// state and result types, and the hex digit decoder.
// No dependencies.
package nsc_pkg;

  localparam int unsigned MaxLine   = 128;
  localparam int unsigned MaxFields = 32;

  localparam logic [7:0] CharDollar  = 8'h24;
  localparam logic [7:0] CharStar    = 8'h2A;
  localparam logic [7:0] CharComma   = 8'h2C;
  localparam logic [7:0] CharNewline = 8'h0A;

  typedef struct packed {
    logic       started;
    logic       star_seen;
    logic [7:0] xor_accum;
    logic [7:0] hex_value;
    logic [1:0] hex_digit_count;
    logic       hex_done;
    logic [5:0] comma_count;
    logic       after_comma;
    logic [7:0] line_length;
    logic       too_long;
  } state_t;

  typedef struct packed {
    logic       sentence_active;
    logic [4:0] field_index;
    logic       field_start;
    logic       is_comma;
    logic       in_checksum;
    logic       line_end;
    logic       checksum_ok;
    logic [5:0] field_count;
    logic [7:0] computed_checksum;
    logic       overflow;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.valid = 1'b1;
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.valid = 1'b1;
      h.value = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.valid = 1'b1;
      h.value = 4'(b - 8'h57);
    end
    return h;
  endfunction

endpackage

### hw/rtl/nmea_sentence_checker_top.sv
// Sentence checker top level: byte handshake, running state and result register.
// Latency: a result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while not stalled; the next state is combinational.
// A new byte is taken while the result register is empty or being emptied.
// Reset clears the running state and the result valid flag.
// Depends on nsc_pkg and nsc_step.
module nmea_sentence_checker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       sentence_active_o,
  output logic [4:0] field_index_o,
  output logic       field_start_o,
  output logic       is_comma_o,
  output logic       in_checksum_o,
  output logic       line_end_o,
  output logic       checksum_ok_o,
  output logic [5:0] field_count_o,
  output logic [7:0] computed_checksum_o,
  output logic       overflow_o
);

  nsc_pkg::state_t  st_q, st_d;
  nsc_pkg::result_t res_q, res_d;
  logic             out_valid_q;
  logic             accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  nsc_step u_step (
    .byte_i(byte_in_i),
    .st_i  (st_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (accept) begin
      st_q        <= st_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign sentence_active_o   = res_q.sentence_active;
  assign field_index_o       = res_q.field_index;
  assign field_start_o       = res_q.field_start;
  assign is_comma_o          = res_q.is_comma;
  assign in_checksum_o       = res_q.in_checksum;
  assign line_end_o          = res_q.line_end;
  assign checksum_ok_o       = res_q.checksum_ok;
  assign field_count_o       = res_q.field_count;
  assign computed_checksum_o = res_q.computed_checksum;
  assign overflow_o          = res_q.overflow;

  // The field count is reported only on the item that ends a line.
  a_count_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !line_end_o |-> field_count_o == 6'd0)
    else $error("field count reported away from line end");

  // A pass needs an asterisk and a line within the length limit.
  a_pass_framing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && checksum_ok_o |-> line_end_o && in_checksum_o && !overflow_o)
    else $error("pass reported without valid framing");

  // Any accepted newline leaves the block outside a sentence.
  a_newline_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && byte_in_i == nsc_pkg::CharNewline |=> !st_q.started)
    else $error("sentence still open after newline");

  // Bytes outside a sentence carry no sentence information.
  a_idle_item_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sentence_active_o |->
      field_index_o == 5'd0 && !in_checksum_o && computed_checksum_o == 8'd0)
    else $error("idle item carries sentence fields");

endmodule

### hw/rtl/nsc_step.sv
// Next-state and result logic for one received byte.
// Depends on nsc_pkg.
module nsc_step (
  input  logic [7:0]      byte_i,
  input  nsc_pkg::state_t st_i,
  output nsc_pkg::state_t st_o,
  output nsc_pkg::result_t res_o
);

  nsc_pkg::hex_t hex;
  logic [6:0]    field_cnt;

  assign hex = nsc_pkg::hex_decode(byte_i);

  always_comb begin
    st_o      = st_i;
    res_o     = '0;
    field_cnt = {1'b0, st_i.comma_count} + 7'd1;
    if (field_cnt > 7'(nsc_pkg::MaxFields)) begin
      field_cnt = 7'(nsc_pkg::MaxFields);
    end

    if (byte_i == nsc_pkg::CharDollar) begin
      // A dollar always opens a fresh sentence, dropping anything before it.
      st_o                  = '0;
      st_o.started          = 1'b1;
      st_o.line_length      = 8'd1;
      res_o.sentence_active = 1'b1;
      res_o.field_start     = 1'b1;
    end else if (!st_i.started) begin
      res_o.line_end = (byte_i == nsc_pkg::CharNewline);
    end else begin
      if (st_i.line_length >= 8'(nsc_pkg::MaxLine)) begin
        st_o.too_long = 1'b1;
      end else begin
        st_o.line_length = st_i.line_length + 8'd1;
      end
      st_o.after_comma      = 1'b0;
      res_o.sentence_active = 1'b1;
      res_o.field_index     = (st_i.comma_count > 6'd31) ? 5'd31 : st_i.comma_count[4:0];
      res_o.field_start     = st_i.after_comma;
      res_o.in_checksum     = st_i.star_seen;

      if (byte_i == nsc_pkg::CharNewline) begin
        res_o.line_end          = 1'b1;
        res_o.checksum_ok       = st_i.star_seen && (st_i.hex_digit_count <= 2'd2) &&
                                  (st_i.hex_value == st_i.xor_accum) && !st_o.too_long;
        res_o.field_count       = field_cnt[5:0];
        res_o.computed_checksum = st_i.xor_accum;
        res_o.overflow          = st_o.too_long;
        st_o                    = '0;
      end else begin
        if (byte_i == nsc_pkg::CharComma) begin
          res_o.is_comma   = 1'b1;
          st_o.after_comma = 1'b1;
          if (st_i.comma_count != 6'd63) begin
            st_o.comma_count = st_i.comma_count + 6'd1;
          end
        end
        if (!st_i.star_seen) begin
          if (byte_i == nsc_pkg::CharStar) begin
            st_o.star_seen = 1'b1;
          end else begin
            st_o.xor_accum = st_i.xor_accum ^ byte_i;
          end
        end else if (!st_i.hex_done) begin
          if (hex.valid) begin
            st_o.hex_value = {st_i.hex_value[3:0], hex.value};
            if (st_i.hex_digit_count != 2'd3) begin
              st_o.hex_digit_count = st_i.hex_digit_count + 2'd1;
            end
          end else begin
            st_o.hex_done = 1'b1;
          end
        end
        res_o.computed_checksum = st_o.xor_accum;
      end
    end
  end

endmodule
